// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Clock is clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
   `ASSERT_SYNC(lbl, (ante) |-> (cons), msg)

`endif

// ===== src/ndte_pkg.sv =====
// Package for the date/time to epoch converter: constants, calendar tables,
// and the stage enable type. No dependencies.
package ndte_pkg;

   localparam int NUM_STAGES = 8;

   // floor(x / 10000) = (x * DIV10K_MUL) >> 34, exact for x < 2**20
   localparam logic [20:0] DIV10K_MUL = 21'd1717987;
   // floor(x / 100) = (x * DIV100_MUL) >> 19, exact for x < 10000
   localparam logic [12:0] DIV100_MUL = 13'd5243;
   localparam logic [13:0] DEC_10K    = 14'd10000;
   localparam logic [6:0]  DEC_100    = 7'd100;

   localparam logic [6:0]  YEAR_PIVOT = 7'd70;
   localparam logic [6:0]  OFF_2000   = 7'd30;
   localparam logic [11:0] SEC_PER_HR = 12'd3600;
   localparam logic [5:0]  SEC_PER_MN = 6'd60;
   localparam logic [16:0] SEC_PER_DY = 17'd86400;
   localparam logic [19:0] US_PER_SEC = 20'd1000000;
   localparam logic [8:0]  DAY_PER_YR = 9'd365;
   localparam logic [6:0]  MON_FEB    = 7'd2;
   localparam logic [6:0]  MON_DEC    = 7'd12;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } split_en_type;

   function automatic logic [4:0] month_days(input logic [6:0] mon);
      logic [4:0] len;
      case (mon)
         7'd1:    len = 5'd31;
         7'd2:    len = 5'd28;
         7'd3:    len = 5'd31;
         7'd4:    len = 5'd30;
         7'd5:    len = 5'd31;
         7'd6:    len = 5'd30;
         7'd7:    len = 5'd31;
         7'd8:    len = 5'd31;
         7'd9:    len = 5'd30;
         7'd10:   len = 5'd31;
         7'd11:   len = 5'd30;
         7'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the months before mon, non-leap year
   function automatic logic [8:0] month_cum(input logic [6:0] mon);
      logic [8:0] cum;
      case (mon)
         7'd1:    cum = 9'd0;
         7'd2:    cum = 9'd31;
         7'd3:    cum = 9'd59;
         7'd4:    cum = 9'd90;
         7'd5:    cum = 9'd120;
         7'd6:    cum = 9'd151;
         7'd7:    cum = 9'd181;
         7'd8:    cum = 9'd212;
         7'd9:    cum = 9'd243;
         7'd10:   cum = 9'd273;
         7'd11:   cum = 9'd304;
         7'd12:   cum = 9'd334;
         default: cum = 9'd0;
      endcase
      return cum;
   endfunction

endpackage

// ===== src/ndte_dec_split.sv =====
// Four-stage split of a six-digit decimal number into its digit pairs.
// Uses ndte_pkg for reciprocal constants and the stage enable type.
module ndte_dec_split (
   input  logic                  clock,
   input  ndte_pkg::split_en_type en,
   input  logic [19:0]           val,
   output logic [6:0]            hi,
   output logic [6:0]            mid,
   output logic [6:0]            lo
);
   import ndte_pkg::*;

   logic [40:0] prod1_ff;
   logic [19:0] val1_ff;
   logic [6:0]  hi2_ff, hi3_ff, hi4_ff;
   logic [13:0] rem2_ff, rem3_ff;
   logic [25:0] prod3_ff;
   logic [6:0]  mid4_ff, lo4_ff;

   logic [6:0]  quo1;
   logic [19:0] quo1_scaled;
   logic [19:0] rem2_full;
   logic [6:0]  mid3;
   logic [13:0] mid3_scaled;
   logic [13:0] lo3_full;

   assign quo1        = prod1_ff[40:34];
   assign quo1_scaled = 20'(quo1) * 20'(DEC_10K);
   assign rem2_full   = val1_ff - quo1_scaled;
   assign mid3        = prod3_ff[25:19];
   assign mid3_scaled = 14'(mid3) * 14'(DEC_100);
   assign lo3_full    = rem3_ff - mid3_scaled;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod1_ff <= 41'(val) * 41'(DIV10K_MUL);
         val1_ff  <= val;
      end
      if (en.s2) begin
         hi2_ff  <= quo1;
         rem2_ff <= rem2_full[13:0];
      end
      if (en.s3) begin
         hi3_ff   <= hi2_ff;
         rem3_ff  <= rem2_ff;
         prod3_ff <= 26'(27'(rem2_ff) * 27'(DIV100_MUL));
      end
      if (en.s4) begin
         hi4_ff  <= hi3_ff;
         mid4_ff <= mid3;
         lo4_ff  <= lo3_full[6:0];
      end
   end

   assign hi  = hi4_ff;
   assign mid = mid4_ff;
   assign lo  = lo4_ff;

endmodule

// ===== src/nmea_datetime_to_epoch_us.sv =====
// Top level: decimal time and date to Unix epoch microseconds.
// Uses ndte_pkg, ndte_dec_split and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_time_hhmmss, req_date_ddmmyy
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_epoch_us, rsp_date_valid
//
// Eight register stages; one transaction per cycle while rsp_stall is low. Depth
// is set by the reciprocal splits (4 stages), the calendar stage, day multiply,
// seconds sum and microsecond multiply. Each stage loads when it is empty or the
// next moves, so bubbles close up under rsp_stall. Reset clears the valid bits.
module nmea_datetime_to_epoch_us (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_time_hhmmss,
   input  logic [19:0]        req_date_ddmmyy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [52:0] rsp_epoch_us,
   output logic               rsp_date_valid
);
   import ndte_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   stage_ready;
   split_en_type          split_en;

   logic [6:0] hh, mi, ss, day, mon, yy;

   // calendar stage
   logic [6:0]  year_off;
   logic        leap;
   logic [4:0]  mon_len;
   logic [8:0]  mon_cum;
   logic [15:0] days_year;
   logic [15:0] days_in;
   logic        ok_in;
   logic [18:0] sod_in;

   logic [15:0] days5_ff;
   logic        ok5_ff, ok6_ff, ok7_ff;
   logic [18:0] sod5_ff, sod6_ff;
   logic [31:0] dprod6_ff;
   logic [31:0] secs7_ff;
   logic [51:0] us_prod;
   logic signed [52:0] epoch8_ff;
   logic        ok8_ff;

   always_comb begin
      stage_ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_stall   = !stage_ready[0];
   assign split_en.s1 = stage_ready[0];
   assign split_en.s2 = stage_ready[1];
   assign split_en.s3 = stage_ready[2];
   assign split_en.s4 = stage_ready[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   ndte_dec_split u_time_split (
      .clock (clock),
      .en    (split_en),
      .val   (req_time_hhmmss),
      .hi    (hh),
      .mid   (mi),
      .lo    (ss)
   );

   ndte_dec_split u_date_split (
      .clock (clock),
      .en    (split_en),
      .val   (req_date_ddmmyy),
      .hi    (day),
      .mid   (mon),
      .lo    (yy)
   );

   // years 1970..2069 only; 2000 is the one century year and it is leap
   assign year_off  = (yy < YEAR_PIVOT) ? (yy + OFF_2000) : (yy - YEAR_PIVOT);
   assign leap      = (yy[1:0] == 2'b00);
   assign mon_len   = month_days(mon) + 5'((mon == MON_FEB) && leap);
   assign mon_cum   = month_cum(mon) + 9'((mon > MON_FEB) && leap);
   assign days_year = 16'(year_off) * 16'(DAY_PER_YR) + 16'((8'(year_off) + 8'd1) >> 2);
   assign days_in   = days_year + 16'(mon_cum) + 16'(day) - 16'd1;
   assign ok_in     = (mon != 7'd0) && (mon <= MON_DEC) && (day != 7'd0)
                      && (day <= 7'(mon_len));
   assign sod_in    = 19'(hh) * 19'(SEC_PER_HR) + 19'(mi) * 19'(SEC_PER_MN) + 19'(ss);

   assign us_prod = 52'(secs7_ff) * 52'(US_PER_SEC);

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         days5_ff <= days_in;
         ok5_ff   <= ok_in;
         sod5_ff  <= sod_in;
      end
      if (stage_ready[5]) begin
         dprod6_ff <= 32'(33'(days5_ff) * 33'(SEC_PER_DY));
         ok6_ff    <= ok5_ff;
         sod6_ff   <= sod5_ff;
      end
      if (stage_ready[6]) begin
         secs7_ff <= dprod6_ff + 32'(sod6_ff);
         ok7_ff   <= ok6_ff;
      end
      if (stage_ready[7]) begin
         epoch8_ff <= ok7_ff ? signed'({1'b0, us_prod}) : '1;
         ok8_ff    <= ok7_ff;
      end
   end

   assign rsp_valid      = valid_ff[NUM_STAGES-1];
   assign rsp_epoch_us   = epoch8_ff;
   assign rsp_date_valid = ok8_ff;

   `include "assert_macros.svh"

   `ASSERT_IMPL(a_invalid_all_ones, rsp_valid && !rsp_date_valid, &rsp_epoch_us, "bad date not -1")
   `ASSERT_IMPL(a_valid_nonneg, rsp_valid && rsp_date_valid, !rsp_epoch_us[52], "negative epoch")
   `ASSERT_IMPL(a_stall_only_full, req_stall, &valid_ff, "input stalled with a bubble")

endmodule
